>>> src/atc_pkg.sv
// Shared types, constants and helpers for the ATC RGB block decoder.
// No dependencies; imported by every module of the decoder.
package atc_pkg;

	localparam int unsigned PixCount = 16;
	localparam int unsigned PalSize = 4;
	localparam int unsigned ModeBit = 15;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		rgb_t [PalSize-1:0] pal;
		logic [2*PixCount-1:0] sel;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	function automatic logic [7:0] mix53(input logic [7:0] a, input logic [7:0] b);
		logic [10:0] s;
		s = 11'(a) * 11'd5 + 11'(b) * 11'd3;
		return s[10:3];
	endfunction

	function automatic logic [7:0] sub_quarter(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] q;
		q = {2'b00, b[7:2]};
		return (a > q) ? (a - q) : 8'd0;
	endfunction

endpackage

>>> src/atc_front.sv
// Front end: takes a block, classifies its mode and builds the palette.
// Depends on atc_pkg.
module atc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [63:0]      block_bits,
	input  atc_pkg::q_stat_t q_stat,
	output logic             busy,
	output logic             push,
	output atc_pkg::entry_t  push_data
);
	import atc_pkg::*;

	logic        valid_s1;
	logic [63:0] block_s1;
	logic        accept;
	logic [15:0] c0;
	logic [15:0] c1;
	rgb_t        ca;
	rgb_t        cb;

	assign busy   = valid_s1 && q_stat.full;
	assign accept = start && !busy;
	assign push   = valid_s1 && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			block_s1 <= block_bits;
		end
	end

	assign c0 = block_s1[15:0];
	assign c1 = block_s1[31:16];

	always_comb begin
		ca.b = widen5(c0[4:0]);
		ca.g = widen5(c0[9:5]);
		ca.r = widen5(c0[14:10]);
		cb.b = widen5(c1[4:0]);
		cb.g = widen6(c1[10:5]);
		cb.r = widen5(c1[15:11]);
		push_data.sel = block_s1[63:32];
		push_data.pal[3] = cb;
		if (!c0[ModeBit]) begin
			push_data.pal[0]   = ca;
			push_data.pal[1].r = mix53(ca.r, cb.r);
			push_data.pal[1].g = mix53(ca.g, cb.g);
			push_data.pal[1].b = mix53(ca.b, cb.b);
			push_data.pal[2].r = mix53(cb.r, ca.r);
			push_data.pal[2].g = mix53(cb.g, ca.g);
			push_data.pal[2].b = mix53(cb.b, ca.b);
		end else begin
			push_data.pal[0]   = '0;
			push_data.pal[1].r = sub_quarter(ca.r, cb.r);
			push_data.pal[1].g = sub_quarter(ca.g, cb.g);
			push_data.pal[1].b = sub_quarter(ca.b, cb.b);
			push_data.pal[2]   = ca;
		end
	end

endmodule

>>> src/atc_queue.sv
// Short queue of decoded palettes between front and back ends.
// Depends on atc_pkg.
module atc_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  atc_pkg::entry_t  push_data,
	input  logic             pop,
	output atc_pkg::entry_t  pop_data,
	output atc_pkg::q_stat_t q_stat
);
	import atc_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic   [PW-1:0] wr_ptr_q;
	logic   [PW-1:0] rd_ptr_q;
	logic   [CW-1:0] count_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> src/atc_back.sv
// Back end: walks the sixteen pixels of a queued block, one per cycle.
// Depends on atc_pkg.
module atc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  atc_pkg::q_stat_t q_stat,
	input  atc_pkg::entry_t  pop_data,
	output logic             pop,
	output logic             strobe,
	output logic [3:0]       pixel_index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic             last
);
	import atc_pkg::*;

	entry_t     cur_q;
	logic       active_q;
	logic [3:0] cnt_q;
	logic       end_pix;
	logic [1:0] sel;
	rgb_t       pix;

	assign end_pix = (cnt_q == 4'(PixCount - 1));
	assign pop     = !q_stat.empty && (!active_q || end_pix);
	assign sel     = cur_q.sel[{cnt_q, 1'b0} +: 2];
	assign pix     = cur_q.pal[sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			strobe   <= 1'b0;
		end else begin
			strobe <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (end_pix) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_data;
		end
		pixel_index <= cnt_q;
		red         <= pix.r;
		green       <= pix.g;
		blue        <= pix.b;
		last        <= end_pix;
	end

endmodule

>>> src/atc_rgb_block_decoder.sv
// Top level of the ATC RGB block decoder: front end, palette queue, back end.
// Depends on atc_pkg, atc_front, atc_queue and atc_back.
//
//   channel | handshake        | payload
//   --------+------------------+---------------------------------------------
//   block   | start / busy     | block_bits
//   pixel   | strobe (no stall)| pixel_index, red, green, blue, last
//
// The back end's pixel counter paces the output; new blocks are taken meanwhile.
// A block passes the front register, the queue and cur_q before its pixels.
// The queue holds QUEUE_DEPTH palettes; busy rises only when the queue and
// the front register are both full. Reset clears all control state.
module atc_rgb_block_decoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] block_bits,
	output logic        strobe,
	output logic [3:0]  pixel_index,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        last
);
	import atc_pkg::*;

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	entry_t  push_data;
	entry_t  pop_data;

	atc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.block_bits (block_bits),
		.q_stat     (q_stat),
		.busy       (busy),
		.push       (push),
		.push_data  (push_data)
	);

	atc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	atc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.pop_data    (pop_data),
		.pop         (pop),
		.strobe      (strobe),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last        (last)
	);

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for atc_rgb_block_decoder: sends 64-bit ATC RGB blocks and
// checks every decoded pixel against a palette decode computed here.
// Depends on the decoder RTL only; stimulus and checking are self-contained.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned PixPerBlock = 16;
	localparam int unsigned MaxReported = 10;

	typedef struct packed {
		logic [3:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       last;
	} pixel_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [63:0] block_bits = '0;
	logic        busy;
	logic        strobe;
	logic [3:0]  pixel_index;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        last;

	pixel_t      expected_pixels[$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	atc_rgb_block_decoder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.block_bits (block_bits),
		.strobe     (strobe),
		.pixel_index(pixel_index),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned widen(input int unsigned v, input int unsigned w);
		return ((v << (8 - w)) & 8'hff) | (v >> (2 * w - 8));
	endfunction

	// Build the four-entry palette and queue the sixteen pixels of one block.
	function automatic void decode_block(input logic [63:0] bits);
		int unsigned c0;
		int unsigned c1;
		int unsigned lo[3];
		int unsigned hi[3];
		int unsigned pal[4][3];
		int unsigned q;
		int unsigned sel;
		pixel_t      px;
		c0 = 32'(bits[15:0]);
		c1 = 32'(bits[31:16]);
		lo[0] = widen(c0 & 'h1f, 5);
		lo[1] = widen((c0 >> 5) & 'h1f, 5);
		lo[2] = widen((c0 >> 10) & 'h1f, 5);
		hi[0] = widen(c1 & 'h1f, 5);
		hi[1] = widen((c1 >> 5) & 'h3f, 6);
		hi[2] = widen((c1 >> 11) & 'h1f, 5);
		for (int ch = 0; ch < 3; ch++) begin
			if (!bits[15]) begin
				pal[0][ch] = lo[ch];
				pal[1][ch] = (5 * lo[ch] + 3 * hi[ch]) / 8;
				pal[2][ch] = (3 * lo[ch] + 5 * hi[ch]) / 8;
				pal[3][ch] = hi[ch];
			end else begin
				q = hi[ch] / 4;
				pal[0][ch] = 0;
				pal[1][ch] = (lo[ch] > q) ? lo[ch] - q : 0;
				pal[2][ch] = lo[ch];
				pal[3][ch] = hi[ch];
			end
		end
		for (int i = 0; i < PixPerBlock; i++) begin
			sel = 32'(bits[32 + 2 * i +: 2]);
			px.idx = 4'(i);
			px.r = 8'(pal[sel][2]);
			px.g = 8'(pal[sel][1]);
			px.b = 8'(pal[sel][0]);
			px.last = (i == PixPerBlock - 1);
			expected_pixels.push_back(px);
		end
	endfunction

	// Check each pixel strobe, then record a block taken at this edge.
	always @(posedge clk) begin
		pixel_t exp_px;
		cycles <= cycles + 1;
		if (arst_n && strobe) begin
			if (expected_pixels.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < MaxReported)
					$display("unexpected pixel: idx %0d rgb %h %h %h last %b",
						pixel_index, red, green, blue, last);
			end else begin
				exp_px = expected_pixels.pop_front();
				if (exp_px.idx !== pixel_index || exp_px.r !== red || exp_px.g !== green
						|| exp_px.b !== blue || exp_px.last !== last) begin
					mismatches <= mismatches + 1;
					if (mismatches < MaxReported)
						$display("pixel mismatch: expected idx %0d rgb %h %h %h last %b,",
							exp_px.idx, exp_px.r, exp_px.g, exp_px.b, exp_px.last,
							" got idx %0d rgb %h %h %h last %b",
							pixel_index, red, green, blue, last);
				end
			end
		end
		if (arst_n && start && !busy)
			decode_block(block_bits);
	end

	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("atc_rgb_block_decoder: mismatch");
			$finish;
		end
	end

	// Optional idle gap with noise on the bus, then hold start until the transaction is taken.
	task automatic send_block(input logic [63:0] bits, input int unsigned idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			block_bits <= {$urandom, $urandom};
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		start <= 1'b1;
		block_bits <= bits;
		do @(posedge clk); while (busy);
	endtask

	task automatic test_extremes();
		send_block(64'h0, 0);
		send_block('1, 0);
		send_block(64'h0000_0000_ffff_7fff, 0);
		send_block(64'hffff_ffff_0000_8000, 0);
		send_block(64'h5555_5555_ffff_ffff, 0);
		send_block(64'haaaa_aaaa_0000_0000, 0);
	endtask

	// Every palette entry in both modes: index patterns 0,1,2,3 and 3,2,1,0 repeated.
	task automatic test_palette_modes();
		send_block(64'he4e4_e4e4_f81f_7c00, 0);
		send_block(64'h1b1b_1b1b_07e0_03e0, 0);
		send_block(64'he4e4_e4e4_f81f_fc00, 0);
		send_block(64'h1b1b_1b1b_07e0_83e0, 0);
		send_block(64'he4e4_e4e4_1234_5678, 0);
		send_block(64'he4e4_e4e4_abcd_cdef, 0);
	endtask

	// Mode 1 middle entry: clamp to zero, exact zero, and above zero.
	task automatic test_mode1_clamp();
		send_block(64'h5555_5555_ffff_8000, 0);
		send_block(64'h5555_5555_ffff_8421, 0);
		send_block(64'h5555_5555_ffff_9ce7, 0);
		send_block(64'h5555_5555_0841_8c63, 0);
		send_block(64'h5555_5555_2104_8421, 0);
	endtask

	task automatic test_random(input int unsigned count, input int unsigned idle_pct);
		logic [63:0] bits;
		for (int n = 0; n < count; n++) begin
			bits = {$urandom, $urandom};
			if ($urandom_range(3) == 0)
				bits[31:0] = {$urandom_range(1) ? 16'hffff : 16'h0000, bits[15:0]};
			send_block(bits, idle_pct);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_palette_modes();
		test_mode1_clamp();
		test_random(80, 0);
		test_random(80, 45);
		test_random(80, 19);
		test_random(60, 0);
		start <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("atc_rgb_block_decoder: match");
		else
			$display("atc_rgb_block_decoder: mismatch");
		$finish;
	end
endmodule

>>> atc_rgb_block_decoder.f
src/atc_pkg.sv
src/atc_front.sv
src/atc_queue.sv
src/atc_back.sv
src/atc_rgb_block_decoder.sv
tb/tb_top.sv
